/* rtl/ect_pkg.sv */
// ----------------------------------------------------------------------------
// ect_pkg
// Shared types and constants of the exposure compensated trigger: register
// indexes, compare value selection, stage control bundles and the constants
// of the exposure to delay scaling.
// ----------------------------------------------------------------------------
package ect_pkg;

  localparam int NOW_W = 32;
  localparam int TPS_W = 26;
  localparam int PER_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  // delay is kept clamped; every value at or above the clamp gives the same results
  localparam int DLY_W = PER_W + 1;
  localparam logic [DLY_W-1:0] DLY_CAP = '1;

  // delay = floor(dt * tps / 2000000), 2000000 = 2^7 * 15625
  localparam int PRE_SHIFT = 7;
  localparam int DIV_ODD = 15625;
  localparam int PROD_W = NOW_W + TPS_W;
  localparam int QUOT_W = PROD_W - PRE_SHIFT;
  localparam int NARROW_W = 31;
  localparam int REC_SHIFT = NARROW_W + 14;
  localparam int REC_W = 32;
  localparam int MUL2_W = NARROW_W + REC_W;
  localparam logic [63:0] RECIP_WIDE =
    ((64'd1 << REC_SHIFT) + 64'(DIV_ODD - 1)) / 64'(DIV_ODD);
  localparam logic [REC_W-1:0] RECIP = RECIP_WIDE[REC_W-1:0];
  localparam logic [QUOT_W-1:0] CAP_QUOT = QUOT_W'(DLY_CAP) * QUOT_W'(DIV_ODD);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLED,
    REG_COMP_EN,
    REG_PERIOD,
    REG_MAX_EXP,
    REG_TPS
  } cfg_reg_t;

  typedef enum logic {
    OP_TIMER,
    OP_EXP_END
  } op_t;

  typedef enum logic [1:0] {
    CV_NONE,
    CV_PERIOD,
    CV_DLY_M1,
    CV_PER_M_DLY
  } cval_sel_t;

  typedef struct packed {
    logic ld_mul;
    logic ld_div;
  } ect_adv_t;

  typedef struct packed {
    logic             fire;
    logic             stamp;
    logic             cvalid;
    cval_sel_t        sel;
    logic             dt_ok;
    logic [NOW_W-1:0] frame;
  } ect_ctl_t;

endpackage

/* rtl/ect_delay_calc.sv */
// ----------------------------------------------------------------------------
// ect_delay_calc
// Two stage scaling of a measured exposure time into timer ticks:
// dt * ticks_per_second, then an exact division by 2000000 through a shift
// and a reciprocal multiply. Result clamped to DLY_CAP.
// ----------------------------------------------------------------------------
module ect_delay_calc
  import ect_pkg::*;
(
  input  logic             clk,
  input  ect_adv_t         adv,
  input  logic [NOW_W-1:0] dt,
  input  logic [TPS_W-1:0] tps,
  output logic [DLY_W-1:0] delay
);

  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_nxt;
  logic [QUOT_W-1:0] quot;
  logic              cap_r;
  logic              cap_nxt;
  logic [MUL2_W-1:0] mul2_r;
  logic [MUL2_W-1:0] mul2_nxt;

  assign prod_nxt = PROD_W'(dt) * PROD_W'(tps);
  assign quot     = prod_r[PROD_W-1:PRE_SHIFT];
  assign cap_nxt  = quot >= CAP_QUOT;
  assign mul2_nxt = MUL2_W'(quot[NARROW_W-1:0]) * MUL2_W'(RECIP);

  always_ff @(posedge clk) begin
    if (adv.ld_mul) begin
      prod_r <= prod_nxt;
    end
    if (adv.ld_div) begin
      cap_r  <= cap_nxt;
      mul2_r <= mul2_nxt;
    end
  end

  assign delay = cap_r ? DLY_CAP : mul2_r[REC_SHIFT+DLY_W-1:REC_SHIFT];

endmodule

/* rtl/exposure_compensated_trigger.sv */
// ----------------------------------------------------------------------------
// exposure_compensated_trigger
// Path: an accepted beat passes the input register, then the control stage, the
// scaling multiply and the result register before it is presented on out_tvalid.
// Throughput: one beat per cycle unless out_tready stalls; the two multipliers
// of the delay scaling are pipelined, so each free stage takes a new beat each cycle.
// Reset: synchronous, active low; clears valid and sequencer state; sets registers to
// enabled 0, compensation 1, period 0, max exposure 0, ticks per second 1.
// ----------------------------------------------------------------------------
module exposure_compensated_trigger
  import ect_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [NOW_W-1:0]      in_tdata,   // [31:0] now_us
  input  logic [1:0]            in_tuser,   // [0] operation, [1] overflowed
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [55:0]           out_tdata,  // [0] fire_trigger, [1] take_timestamp,
                                            // [2] compare_valid, [18:3] compare_value,
                                            // [50:19] frame_number, [55:51] zero
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic              enabled_r;
  logic              comp_en_r;
  logic [PER_W-1:0]  period_r;
  logic [NOW_W-1:0]  max_exp_r;
  logic [TPS_W-1:0]  tps_r;

  logic              exposing_r,     exposing_nxt;
  logic              compensating_r, compensating_nxt;
  logic [NOW_W-1:0]  exp_start_r,    exp_start_nxt;
  logic [NOW_W-1:0]  frame_count_r,  frame_count_nxt;
  logic [DLY_W-1:0]  delay_r,        delay_nxt;

  logic              s1_valid_r;
  op_t               s1_op_r;
  logic              s1_ovf_r;
  logic [NOW_W-1:0]  s1_now_r;
  logic              s2_valid_r;
  ect_ctl_t          s2_ctl_r;
  logic              s3_valid_r;
  ect_ctl_t          s3_ctl_r;
  logic              out_valid_r;
  logic              out_fire_r;
  logic              out_stamp_r;
  logic              out_cvalid_r;
  logic [PER_W-1:0]  out_cval_r;
  logic [NOW_W-1:0]  out_frame_r;

  logic              out_free;
  logic              s3_ready;
  logic              s2_ready;
  logic              in_acc;
  ect_adv_t          adv;
  logic              adv_out;

  logic [NOW_W-1:0]  dt;
  logic              dt_bad;
  ect_ctl_t          ctl_nxt;
  logic [DLY_W-1:0]  calc_delay;
  logic [DLY_W-1:0]  dly_m1;
  logic [PER_W-1:0]  cval_nxt;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
      comp_en_r <= 1'b1;
      period_r  <= '0;
      max_exp_r <= '0;
      tps_r     <= TPS_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ENABLED: enabled_r <= cfg_data[0];
        REG_COMP_EN: comp_en_r <= cfg_data[0];
        REG_PERIOD:  period_r  <= cfg_data[PER_W-1:0];
        REG_MAX_EXP: max_exp_r <= cfg_data[NOW_W-1:0];
        REG_TPS:     tps_r     <= cfg_data[TPS_W-1:0];
        default: ;
      endcase
    end
  end

  // stage handshake
  assign out_free   = !out_valid_r || out_tready;
  assign s3_ready   = !s3_valid_r || out_free;
  assign s2_ready   = !s2_valid_r || s3_ready;
  assign in_tready  = !s1_valid_r || s2_ready;
  assign in_acc     = in_tvalid && in_tready;
  assign adv        = '{ld_mul: s1_valid_r && s2_ready, ld_div: s2_valid_r && s3_ready};
  assign adv_out    = s3_valid_r && out_free;

  // control stage: sequencing flags, exposure start and frame count
  assign dt     = s1_now_r - exp_start_r;
  assign dt_bad = (dt == '0) || (dt >= max_exp_r);

  always_comb begin
    exposing_nxt     = exposing_r;
    compensating_nxt = compensating_r;
    exp_start_nxt    = exp_start_r;
    frame_count_nxt  = frame_count_r;
    ctl_nxt          = '0;
    ctl_nxt.sel      = CV_NONE;
    unique case (s1_op_r)
      OP_TIMER: begin
        if (s1_ovf_r && enabled_r) begin
          ctl_nxt.cvalid = 1'b1;
          if (comp_en_r && compensating_r) begin
            if (!exposing_r) begin
              exposing_nxt    = 1'b1;
              ctl_nxt.fire    = 1'b1;
              exp_start_nxt   = s1_now_r;
              frame_count_nxt = frame_count_r + NOW_W'(1);
              ctl_nxt.sel     = CV_DLY_M1;
            end else begin
              ctl_nxt.stamp    = 1'b1;
              compensating_nxt = 1'b0;
              ctl_nxt.sel      = CV_PERIOD;
            end
          end else begin
            exposing_nxt    = 1'b1;
            ctl_nxt.fire    = 1'b1;
            ctl_nxt.stamp   = 1'b1;
            exp_start_nxt   = s1_now_r;
            frame_count_nxt = frame_count_r + NOW_W'(1);
            ctl_nxt.sel     = CV_PERIOD;
          end
        end
      end
      OP_EXP_END: begin
        if (comp_en_r) begin
          compensating_nxt = !dt_bad;
          exposing_nxt     = 1'b0;
          ctl_nxt.cvalid   = 1'b1;
          ctl_nxt.sel      = CV_PER_M_DLY;
          ctl_nxt.dt_ok    = !dt_bad;
        end
      end
      default: ;
    endcase
    ctl_nxt.frame = frame_count_nxt;
  end

  ect_delay_calc u_delay_calc (
    .clk   (clk),
    .adv   (adv),
    .dt    (dt),
    .tps   (tps_r),
    .delay (calc_delay)
  );

  // result stage: compare value and delay update
  assign dly_m1 = delay_r - DLY_W'(1);

  always_comb begin
    delay_nxt = delay_r;
    cval_nxt  = '0;
    case (s3_ctl_r.sel)
      CV_NONE:   cval_nxt = '0;
      CV_PERIOD: cval_nxt = period_r;
      CV_DLY_M1: begin
        if (delay_r == '0) begin
          cval_nxt = period_r;
        end else if (|dly_m1[DLY_W-1:PER_W]) begin
          cval_nxt = '1;
        end else begin
          cval_nxt = dly_m1[PER_W-1:0];
        end
      end
      CV_PER_M_DLY: begin
        delay_nxt = s3_ctl_r.dt_ok ? calc_delay : '0;
        if (DLY_W'(period_r) > delay_nxt) begin
          cval_nxt = period_r - delay_nxt[PER_W-1:0];
        end else begin
          cval_nxt = '0;
        end
      end
      default: cval_nxt = '0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      s2_valid_r     <= 1'b0;
      s3_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      exposing_r     <= 1'b0;
      compensating_r <= 1'b0;
      exp_start_r    <= '0;
      frame_count_r  <= '0;
      delay_r        <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (adv.ld_mul) begin
        s1_valid_r <= 1'b0;
      end
      if (adv.ld_mul) begin
        s2_valid_r     <= 1'b1;
        exposing_r     <= exposing_nxt;
        compensating_r <= compensating_nxt;
        exp_start_r    <= exp_start_nxt;
        frame_count_r  <= frame_count_nxt;
      end else if (adv.ld_div) begin
        s2_valid_r <= 1'b0;
      end
      if (adv.ld_div) begin
        s3_valid_r <= 1'b1;
      end else if (adv_out) begin
        s3_valid_r <= 1'b0;
      end
      if (adv_out) begin
        out_valid_r <= 1'b1;
        delay_r     <= delay_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r  <= op_t'(in_tuser[0]);
      s1_ovf_r <= in_tuser[1];
      s1_now_r <= in_tdata;
    end
    if (adv.ld_mul) begin
      s2_ctl_r <= ctl_nxt;
    end
    if (adv.ld_div) begin
      s3_ctl_r <= s2_ctl_r;
    end
    if (adv_out) begin
      out_fire_r   <= s3_ctl_r.fire;
      out_stamp_r  <= s3_ctl_r.stamp;
      out_cvalid_r <= s3_ctl_r.cvalid;
      out_cval_r   <= cval_nxt;
      out_frame_r  <= s3_ctl_r.frame;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_frame_r, out_cval_r, out_cvalid_r, out_stamp_r, out_fire_r};

  // checks
  a_frame_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$stable(frame_count_r) |-> $past(adv.ld_mul && ctl_nxt.fire))
    else $error("frame count moved without a trigger");

  a_cval_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_cvalid_r |-> out_cval_r == '0)
    else $error("compare value set without compare_valid");

  a_fire_sets_compare: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_fire_r |-> out_cvalid_r)
    else $error("trigger without a new compare value");

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb: exposure_compensated_trigger
// Drives timer and exposure-end events into the trigger sequencer. An
// event-level predictor computes the expected trigger, timestamp, compare
// value and frame count for each beat. A directed table covers register
// extremes, ignored events, bad exposures, delay saturation and period
// clamping. Random phases with fresh register settings follow. Both stream
// sides idle in random bursts, and once the result side holds off long enough
// to back the block up.
// ----------------------------------------------------------------------------
module tb;
  import ect_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          LIMIT_CYCLES  = 500000;
  localparam logic [63:0] DELAY_DIVISOR = 64'd2000000;
  localparam int          PHASES        = 8;
  localparam int          PHASE_ITEMS   = 200;

  typedef struct packed {
    logic        fire;
    logic        stamp;
    logic        cvalid;
    logic [15:0] cval;
    logic [31:0] frame;
  } trig_res_t;

  typedef struct packed {
    logic        is_cfg;
    cfg_reg_t    idx;
    op_t         op;
    logic        ovf;
    logic [31:0] value;
    logic        typed;
    trig_res_t   want;
  } plan_row_t;

  localparam plan_row_t PLAN [0:35] = '{
    '{1'b0, REG_ENABLED, OP_TIMER,   1'b1, 32'd0,        1'b1, '{1'b0, 1'b0, 1'b0, 16'd0, 32'd0}},
    '{1'b0, REG_ENABLED, OP_EXP_END, 1'b0, 32'hFFFFFFFF, 1'b1, '{1'b0, 1'b0, 1'b1, 16'd0, 32'd0}},
    '{1'b1, REG_ENABLED, OP_TIMER,   1'b0, 32'd1,        1'b0, '0},
    '{1'b1, REG_PERIOD,  OP_TIMER,   1'b0, 32'd1000,     1'b0, '0},
    '{1'b1, REG_MAX_EXP, OP_TIMER,   1'b0, 32'hFFFFFFFF, 1'b0, '0},
    '{1'b1, REG_TPS,     OP_TIMER,   1'b0, 32'h03FFFFFF, 1'b0, '0},
    '{1'b0, REG_ENABLED, OP_TIMER,   1'b0, 32'd5,        1'b1, '{1'b0, 1'b0, 1'b0, 16'd0, 32'd0}},
    '{1'b0, REG_ENABLED, OP_TIMER,   1'b1, 32'd0,        1'b1, '{1'b1, 1'b1, 1'b1, 16'd1000, 32'd1}},
    '{1'b0, REG_ENABLED, OP_EXP_END, 1'b0, 32'd2000,     1'b1, '{1'b0, 1'b0, 1'b1, 16'd0, 32'd1}},
    '{1'b0, REG_ENABLED, OP_TIMER,   1'b1, 32'd100,      1'b1, '{1'b1, 1'b0, 1'b1, 16'hFFFF, 32'd2}},
    '{1'b0, REG_ENABLED, OP_TIMER,   1'b1, 32'd200,      1'b1, '{1'b0, 1'b1, 1'b1, 16'd1000, 32'd2}},
    '{1'b0, REG_ENABLED, OP_EXP_END, 1'b0, 32'd100,      1'b1, '{1'b0, 1'b0, 1'b1, 16'd1000, 32'd2}},
    '{1'b0, REG_ENABLED, OP_EXP_END, 1'b0, 32'h00000054, 1'b1, '{1'b0, 1'b0, 1'b1, 16'd0, 32'd2}},
    '{1'b0, REG_ENABLED, OP_TIMER,   1'b1, 32'd1,        1'b1, '{1'b1, 1'b0, 1'b1, 16'hFFFF, 32'd3}},
    '{1'b0, REG_ENABLED, OP_EXP_END, 1'b0, 32'd0,        1'b1, '{1'b0, 1'b0, 1'b1, 16'd1000, 32'd3}},
    '{1'b1, REG_COMP_EN, OP_TIMER,   1'b0, 32'd0,        1'b0, '0},
    '{1'b0, REG_ENABLED, OP_EXP_END, 1'b1, 32'd12345,    1'b1, '{1'b0, 1'b0, 1'b0, 16'd0, 32'd3}},
    '{1'b0, REG_ENABLED, OP_TIMER,   1'b1, 32'd7,        1'b1, '{1'b1, 1'b1, 1'b1, 16'd1000, 32'd4}},
    '{1'b1, REG_COMP_EN, OP_TIMER,   1'b0, 32'd1,        1'b0, '0},
    '{1'b1, REG_PERIOD,  OP_TIMER,   1'b0, 32'h0000FFFF, 1'b0, '0},
    '{1'b1, REG_MAX_EXP, OP_TIMER,   1'b0, 32'd1000,     1'b0, '0},
    '{1'b1, REG_TPS,     OP_TIMER,   1'b0, 32'd0,        1'b0, '0},
    '{1'b0, REG_ENABLED, OP_EXP_END, 1'b0, 32'd507,      1'b1, '{1'b0, 1'b0, 1'b1, 16'hFFFF, 32'd4}},
    '{1'b0, REG_ENABLED, OP_TIMER,   1'b1, 32'd600,      1'b1, '{1'b1, 1'b0, 1'b1, 16'hFFFF, 32'd5}},
    '{1'b0, REG_ENABLED, OP_TIMER,   1'b1, 32'd601,      1'b1, '{1'b0, 1'b1, 1'b1, 16'hFFFF, 32'd5}},
    '{1'b1, REG_PERIOD,  OP_TIMER,   1'b0, 32'd300,      1'b0, '0},
    '{1'b1, REG_TPS,     OP_TIMER,   1'b0, 32'd2000000,  1'b0, '0},
    '{1'b0, REG_ENABLED, OP_EXP_END, 1'b0, 32'd1599,     1'b0, '0},
    '{1'b0, REG_ENABLED, OP_TIMER,   1'b1, 32'd2000,     1'b0, '0},
    '{1'b0, REG_ENABLED, OP_TIMER,   1'b1, 32'd2100,     1'b0, '0},
    '{1'b0, REG_ENABLED, OP_EXP_END, 1'b0, 32'd2001,     1'b0, '0},
    '{1'b0, REG_ENABLED, OP_TIMER,   1'b1, 32'd2500,     1'b0, '0},
    '{1'b0, REG_ENABLED, OP_EXP_END, 1'b0, 32'd3500,     1'b0, '0},
    '{1'b1, REG_ENABLED, OP_TIMER,   1'b0, 32'd0,        1'b0, '0},
    '{1'b0, REG_ENABLED, OP_TIMER,   1'b1, 32'd3600,     1'b1, '{1'b0, 1'b0, 1'b0, 16'd0, 32'd7}},
    '{1'b0, REG_ENABLED, OP_EXP_END, 1'b0, 32'd3601,     1'b0, '0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [NOW_W-1:0]      in_tdata = '0;
  logic [1:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [55:0]           out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // register shadow
  logic        reg_enabled  = 1'b0;
  logic        reg_comp_en  = 1'b1;
  logic [15:0] reg_period   = '0;
  logic [31:0] reg_max_exp  = '0;
  logic [25:0] reg_tps      = 26'd1;

  // sequencer state
  logic        exposing     = 1'b0;
  logic        compensating = 1'b0;
  logic [31:0] exp_start    = '0;
  logic [31:0] delay_ticks  = '0;
  logic [31:0] frames       = '0;

  trig_res_t   pending_results [$];
  int          fails = 0;
  int          cycles = 0;
  int          events_sent = 0;
  int          results_seen = 0;
  int          reg_writes = 0;
  int          fired = 0;
  int          stamped = 0;
  logic        calm = 1'b0;
  logic        pressure_done = 1'b0;

  exposure_compensated_trigger dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic trig_res_t advance_trigger(op_t op, logic ovf, logic [31:0] now);
    trig_res_t   r;
    logic [31:0] span;
    logic [63:0] scaled;
    r = '0;
    if (op == OP_TIMER) begin
      if (ovf && reg_enabled) begin
        r.cvalid = 1'b1;
        if (reg_comp_en && compensating) begin
          if (!exposing) begin
            exposing = 1'b1;
            r.fire = 1'b1;
            exp_start = now;
            frames = frames + 32'd1;
            if (delay_ticks == 32'd0)
              r.cval = reg_period;
            else
              r.cval = (delay_ticks - 32'd1 > 32'hFFFF) ? 16'hFFFF : 16'(delay_ticks - 32'd1);
          end else begin
            r.stamp = 1'b1;
            compensating = 1'b0;
            r.cval = reg_period;
          end
        end else begin
          exposing = 1'b1;
          r.fire = 1'b1;
          r.stamp = 1'b1;
          exp_start = now;
          frames = frames + 32'd1;
          r.cval = reg_period;
        end
      end
    end else if (reg_comp_en) begin
      span = now - exp_start;
      if (span == 32'd0 || span >= reg_max_exp) begin
        delay_ticks = '0;
        compensating = 1'b0;
      end else begin
        scaled = (64'(span) * 64'(reg_tps)) / DELAY_DIVISOR;
        delay_ticks = (scaled > 64'hFFFFFFFF) ? 32'hFFFFFFFF : scaled[31:0];
        compensating = 1'b1;
      end
      exposing = 1'b0;
      r.cvalid = 1'b1;
      r.cval = (32'(reg_period) > delay_ticks) ? 16'(32'(reg_period) - delay_ticks) : 16'd0;
    end
    r.frame = frames;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ENABLED: reg_enabled = value[0];
      REG_COMP_EN: reg_comp_en = value[0];
      REG_PERIOD:  reg_period  = value[15:0];
      REG_MAX_EXP: reg_max_exp = value;
      REG_TPS:     reg_tps     = value[25:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
  endtask

  task automatic offer_event(op_t op, logic ovf, logic [31:0] now, logic typed, trig_res_t want);
    trig_res_t pred;
    int        gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {ovf, op};
    in_tdata  <= now;
    do @(posedge clk); while (!in_tready);
    pred = advance_trigger(op, ovf, now);
    pending_results.push_back(typed ? want : pred);
    events_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("exposure_compensated_trigger: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    trig_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      fired   += out_tdata[0];
      stamped += out_tdata[1];
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: %0h", out_tdata);
        fails++;
      end else begin
        want = pending_results.pop_front();
        check_field("fire_trigger", 32'(want.fire), 32'(out_tdata[0]));
        check_field("take_timestamp", 32'(want.stamp), 32'(out_tdata[1]));
        check_field("compare_valid", 32'(want.cvalid), 32'(out_tdata[2]));
        check_field("compare_value", 32'(want.cval), 32'(out_tdata[18:3]));
        check_field("frame_number", want.frame, out_tdata[50:19]);
      end
    end
  end

  // result side: random stall bursts, one long hold-off to back up the pipeline
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (!pressure_done && results_seen >= 300) begin
        pressure_done = 1'b1;
        hold = 300;
      end
      if (hold > 0) begin
        out_tready <= 1'b0;
        hold--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(0, 13);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    logic        prev_cfg;
    logic [31:0] now_us;
    logic [31:0] step_span;
    logic [31:0] max_exp;
    int          pick;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    prev_cfg = 1'b0;
    foreach (PLAN[i]) begin
      if (PLAN[i].is_cfg) begin
        if (!prev_cfg) settle();
        write_reg(PLAN[i].idx, PLAN[i].value);
      end else begin
        if (prev_cfg) cfg_valid <= 1'b0;
        offer_event(PLAN[i].op, PLAN[i].ovf, PLAN[i].value, PLAN[i].typed, PLAN[i].want);
      end
      prev_cfg = PLAN[i].is_cfg;
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      if (ph == 1) max_exp = 32'd0;
      else if (ph == 2) max_exp = 32'hFFFFFFFF;
      else max_exp = $urandom_range(1, 32'h0004_0000);
      write_reg(REG_ENABLED, 32'(ph != 3));
      write_reg(REG_COMP_EN, 32'(ph != 5));
      write_reg(REG_PERIOD, (ph == 1) ? 32'd0 : (ph == 2) ? 32'hFFFF : $urandom_range(0, 32'hFFFF));
      write_reg(REG_MAX_EXP, max_exp);
      write_reg(REG_TPS, (ph == 1) ? 32'd1 : (ph == 2) ? 32'h03FFFFFF
                                           : $urandom_range(1, 32'h03FFFFFF));
      cfg_valid <= 1'b0;
      now_us = $urandom;
      step_span = $urandom_range(1, 32'h0002_0000);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        calm = (ph == PHASES - 1) && (k >= PHASE_ITEMS / 4);
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          now_us = now_us + $urandom_range(0, step_span);
          offer_event(OP_TIMER, 1'b1, now_us, 1'b0, '0);
        end else if (pick < 80) begin
          now_us = now_us + $urandom_range(0, step_span);
          offer_event(OP_EXP_END, 1'($urandom_range(0, 1)), now_us, 1'b0, '0);
        end else if (pick < 90) begin
          offer_event(OP_TIMER, 1'b0, $urandom, 1'b0, '0);
        end else begin
          offer_event(op_t'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom,
                      1'b0, '0);
        end
      end
    end

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);

    $display("covered %0d events over %0d register writes and %0d setting phases",
             events_sent, reg_writes, PHASES + 1);
    $display("results checked: %0d, triggers fired: %0d, timestamps taken: %0d",
             results_seen, fired, stamped);
    if (fails == 0)
      $display("exposure_compensated_trigger: match");
    else
      $display("exposure_compensated_trigger: mismatch");
    $finish;
  end

endmodule
